// File: hdl/qcia_pkg.sv
// Package for the cut-in-after queue: word formats, operation and status codes,
// and the control group shared between the top level and its cells. No dependencies.
package qcia_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_CUT  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int OUT_WIDTH   = 32;
    localparam int COUNT_WIDTH = 5;

    typedef struct packed {
        logic [1:0]                  opcode;
        logic signed [OUT_WIDTH-1:0] anchor_value;
        logic signed [OUT_WIDTH-1:0] mover_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic signed [OUT_WIDTH-1:0] front_value;
        logic signed [OUT_WIDTH-1:0] popped_value;
        logic [COUNT_WIDTH-1:0]      entry_count;
    } out_word_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic       cmp_en;
        logic       upd_en;
        logic [1:0] op;
        logic       found;
    } ctrl_t;

    // Search flags rippling from the front of the row to the back.
    typedef struct packed {
        logic anchor_seen;
        logic mover_seen;
        logic anchor_hit;
    } link_t;

endpackage

// File: hdl/qcia_cell.sv
// One queue position of the cut-in-after queue: holds one entry, its match flags,
// and passes search flags to the next position. Depends on qcia_pkg.
module qcia_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  qcia_pkg::ctrl_t        ctrl,
    input  logic [VALUE_WIDTH-1:0] cmp_anchor,
    input  logic [VALUE_WIDTH-1:0] cmp_mover,
    input  logic [VALUE_WIDTH-1:0] anchor_hold,
    input  logic [VALUE_WIDTH-1:0] mover_hold,
    input  logic                   occ,
    input  logic                   left_occ,
    input  logic [VALUE_WIDTH-1:0] left_value,
    input  logic [VALUE_WIDTH-1:0] right_value,
    input  qcia_pkg::link_t        left_link,
    output qcia_pkg::link_t        right_link,
    output logic [VALUE_WIDTH-1:0] value,
    output logic [VALUE_WIDTH-1:0] value_upd
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   eq_anchor_reg;
    logic                   eq_mover_reg;
    logic                   in_span;

    // The flags are taken in the cycle the word is accepted; the entries only
    // change in the update cycle, so they still describe the queue then.
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            eq_anchor_reg <= occ & (cmp_anchor == value_reg);
            eq_mover_reg  <= occ & (cmp_mover == value_reg);
        end
        if (ctrl.upd_en)
        begin
            value_reg <= value_upd;
        end
    end

    always_comb
    begin
        right_link.anchor_hit  = eq_anchor_reg & ~left_link.anchor_seen;
        right_link.anchor_seen = left_link.anchor_seen | eq_anchor_reg;
        right_link.mover_seen  = left_link.mover_seen
                               | (eq_mover_reg & left_link.anchor_seen);
    end

    // A position lies in the moved span when it is past the anchor and not past
    // the mover; the first one of the span takes the mover itself.
    assign in_span = ctrl.found & left_link.anchor_seen & ~left_link.mover_seen;

    always_comb
    begin
        value_upd = value_reg;
        unique case (ctrl.op)
            qcia_pkg::OP_PUSH:
            begin
                if (~occ & left_occ)
                begin
                    value_upd = anchor_hold;
                end
            end
            qcia_pkg::OP_POP:
            begin
                value_upd = right_value;
            end
            qcia_pkg::OP_CUT:
            begin
                if (in_span)
                begin
                    value_upd = left_link.anchor_hit ? mover_hold : left_value;
                end
            end
            default:
            begin
                value_upd = value_reg;
            end
        endcase
    end

    assign value = value_reg;

endmodule

// File: hdl/queue_cut_in_after_unit.sv
// Top level of the cut-in-after queue: handshake, fill count, result register and
// the row of queue cells. Depends on qcia_pkg and qcia_cell.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+---------------------
//   in      | input     | in_valid/in_stall  | qcia_pkg::in_word_t
//   out     | output    | out_valid/out_stall| qcia_pkg::out_word_t
//
// Each word is handled in an accept cycle, in which each cell compares its entry
// with both search values, and then in an update cycle, in which the search flags ripple
// along the row and every cell loads its new entry. The row holds a single command.
// Reset clears the fill count, the pending-update flag and out_valid; entries need no reset.
// The update waits while a finished result is stalled, and in_stall stays high
// until that update is done.
module queue_cut_in_after_unit #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  qcia_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output qcia_pkg::out_word_t out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = qcia_pkg::OUT_WIDTH;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   upd_pending_reg;
    logic                   out_valid_reg;
    qcia_pkg::out_word_t    out_data_reg;
    qcia_pkg::out_word_t    out_data_next;
    logic [1:0]             op_reg;
    logic [VALUE_WIDTH-1:0] anchor_reg;
    logic [VALUE_WIDTH-1:0] mover_reg;
    logic [VALUE_WIDTH-1:0] anchor_in;
    logic [VALUE_WIDTH-1:0] mover_in;
    logic [OW-1:0]          front_out;
    logic [OW-1:0]          head_out;
    logic                   accept;
    logic                   upd_go;
    logic [DEPTH-1:0]       occ;
    qcia_pkg::ctrl_t        ctrl;
    qcia_pkg::link_t        links [DEPTH+1];
    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_upd [DEPTH];

    // Values are kept at VALUE_WIDTH bits; outputs are sign-extended or cut to 32 bits.
    generate
        if (VALUE_WIDTH <= OW)
        begin : g_narrow
            assign anchor_in = in_data.anchor_value[VALUE_WIDTH-1:0];
            assign mover_in  = in_data.mover_value[VALUE_WIDTH-1:0];
        end
        else
        begin : g_wide
            assign anchor_in = {{(VALUE_WIDTH-OW){in_data.anchor_value[OW-1]}},
                                in_data.anchor_value};
            assign mover_in  = {{(VALUE_WIDTH-OW){in_data.mover_value[OW-1]}},
                                in_data.mover_value};
        end

        if (VALUE_WIDTH >= OW)
        begin : g_out_cut
            assign front_out = cell_upd[0][OW-1:0];
            assign head_out  = cell_value[0][OW-1:0];
        end
        else
        begin : g_out_ext
            assign front_out = {{(OW-VALUE_WIDTH){cell_upd[0][VALUE_WIDTH-1]}}, cell_upd[0]};
            assign head_out  = {{(OW-VALUE_WIDTH){cell_value[0][VALUE_WIDTH-1]}},
                                cell_value[0]};
        end
    endgenerate

    assign in_stall  = upd_pending_reg;
    assign accept    = in_valid & ~upd_pending_reg;
    assign upd_go    = upd_pending_reg & (~out_valid_reg | ~out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign ctrl.cmp_en = accept;
    assign ctrl.upd_en = upd_go;
    assign ctrl.op     = op_reg;
    assign ctrl.found  = links[DEPTH].mover_seen;

    assign links[0] = '0;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            assign occ[i] = CW'(i) < count_reg;

            qcia_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .cmp_anchor  (anchor_in),
                .cmp_mover   (mover_in),
                .anchor_hold (anchor_reg),
                .mover_hold  (mover_reg),
                .occ         (occ[i]),
                .left_occ    ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i-1]),
                .left_value  ((i == 0) ? '0 : cell_value[(i == 0) ? 0 : i-1]),
                .right_value ((i == DEPTH-1) ? '0 : cell_value[(i == DEPTH-1) ? i : i+1]),
                .left_link   (links[i]),
                .right_link  (links[i+1]),
                .value       (cell_value[i]),
                .value_upd   (cell_upd[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next                 = count_reg;
        out_data_next.status       = qcia_pkg::ST_OK;
        out_data_next.popped_value = '0;
        unique case (op_reg)
            qcia_pkg::OP_PUSH:
            begin
                if (count_reg == CW'(DEPTH))
                begin
                    out_data_next.status = qcia_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            qcia_pkg::OP_POP:
            begin
                if (count_reg == '0)
                begin
                    out_data_next.status = qcia_pkg::ST_EMPTY;
                end
                else
                begin
                    out_data_next.popped_value = head_out;
                    count_next                 = count_reg - CW'(1);
                end
            end
            qcia_pkg::OP_CUT:
            begin
                if (!links[DEPTH].mover_seen)
                begin
                    out_data_next.status = qcia_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        out_data_next.front_value = (count_next != '0) ? front_out : '0;
        out_data_next.entry_count = qcia_pkg::COUNT_WIDTH'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            upd_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                upd_pending_reg <= 1'b1;
            end
            else if (upd_go)
            begin
                upd_pending_reg <= 1'b0;
            end

            if (upd_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= in_data.opcode;
            anchor_reg <= anchor_in;
            mover_reg  <= mover_in;
        end
        if (upd_go)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
